>>> rtl/rcbox_pkg.sv
package rcbox_pkg;

    localparam int DATA_W    = 16;
    localparam int SUM_W     = 20;
    localparam int CFG_IDX_W = 2;

    // Item modes
    localparam logic [1:0] MODE_SAMPLE     = 2'd0;
    localparam logic [1:0] MODE_CONNECT    = 2'd1;
    localparam logic [1:0] MODE_DISCONNECT = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH   = 2'd2;

    // Snap band limits on the window mean
    localparam logic [SUM_W-1:0] SNAP_DEAD_MAX   = 20'd800;
    localparam logic [SUM_W-1:0] SNAP_LOW_END    = 20'd1010;
    localparam logic [SUM_W-1:0] SNAP_HIGH_START = 20'd1990;
    localparam logic [SUM_W-1:0] SNAP_MID_LO     = 20'd1480;
    localparam logic [SUM_W-1:0] SNAP_MID_HI     = 20'd1520;

    typedef struct packed {
        logic [1:0]        mode;
        logic [DATA_W-1:0] steer_raw;
        logic [DATA_W-1:0] motor_raw;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] steer_out;
        logic [DATA_W-1:0] motor_out;
    } out_item_t;

    typedef struct packed {
        logic shift;
        logic fill;
    } cell_ctrl_t;

    function automatic logic [DATA_W-1:0] snap_mean(
        input logic [SUM_W-1:0]  mean,
        input logic [DATA_W-1:0] center,
        input logic [DATA_W-1:0] low,
        input logic [DATA_W-1:0] high
    );
        logic [DATA_W-1:0] res;
        if (mean <= SNAP_DEAD_MAX) begin
            res = center;
        end else if (mean < SNAP_LOW_END) begin
            res = low;
        end else if (mean > SNAP_HIGH_START) begin
            res = high;
        end else if ((mean > SNAP_MID_LO) && (mean < SNAP_MID_HI)) begin
            res = center;
        end else begin
            res = mean[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/rcbox_cell.sv
module rcbox_cell import rcbox_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] center,
    input  logic [DATA_W-1:0] steer_in,
    input  logic [DATA_W-1:0] motor_in,
    output logic [DATA_W-1:0] steer_q,
    output logic [DATA_W-1:0] motor_q
);

    logic [DATA_W-1:0] steer_reg, steer_next;
    logic [DATA_W-1:0] motor_reg, motor_next;

    // Fill wins over shift; they never coincide anyway.
    always_comb begin
        steer_next = steer_reg;
        motor_next = motor_reg;
        if (ctrl.fill) begin
            steer_next = center;
            motor_next = center;
        end else if (ctrl.shift) begin
            steer_next = steer_in;
            motor_next = motor_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steer_reg <= '0;
            motor_reg <= '0;
        end else begin
            steer_reg <= steer_next;
            motor_reg <= motor_next;
        end
    end

    assign steer_q = steer_reg;
    assign motor_q = motor_reg;

endmodule

>>> rtl/rcbox_div.sv
module rcbox_div import rcbox_pkg::*; #(
    parameter int WINDOW_LENGTH = 4
) (
    input  logic             aclk,
    input  logic             load,
    input  logic [SUM_W-1:0] sum_in,
    output logic [SUM_W-1:0] mean
);

    // floor(2^SUM_W / N); estimate is at most one below the true quotient
    localparam logic [SUM_W:0]   RECIP = (SUM_W+1)'((64'd1 << SUM_W) / WINDOW_LENGTH);
    localparam logic [SUM_W-1:0] DIVISOR = SUM_W'(WINDOW_LENGTH);

    logic [2*SUM_W:0] prod_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] q_est;
    logic [SUM_W-1:0] q_times_n;
    logic [SUM_W-1:0] rem;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= (2*SUM_W+1)'(sum_in) * RECIP;
            sum_reg  <= sum_in;
        end
    end

    always_comb begin
        q_est     = prod_reg[2*SUM_W-1:SUM_W];
        q_times_n = SUM_W'(q_est * DIVISOR);
        rem       = sum_reg - q_times_n;
        mean      = (rem >= DIVISOR) ? (q_est + SUM_W'(1)) : q_est;
    end

endmodule

>>> rtl/rc_channel_boxcar_snap_filter.sv
// Two-channel RC stick conditioner (steer and motor). A connect item arms
// sampling; a disconnect item loads every window entry with the centre value
// and disarms it. While armed, each sample item substitutes the centre value
// for a raw zero, pushes both values into a WINDOW_LENGTH-deep chain of cells
// (oldest entry falls off the end) and yields one result item holding each
// channel's window mean, snapped to centre, low or high in the dead bands.
// Connect, disconnect, mode 3 and samples while disarmed give no result.
// Throughput is one item per clock when not stalled; a sample passes three
// registered stages (running sum, reciprocal multiply, correct-and-snap). The
// input stalls only when all three hold items and m_ready is low. The user must
// write configuration (cfg_wr_en/cfg_index/cfg_wdata) only while idle; unenforced.
module rc_channel_boxcar_snap_filter import rcbox_pkg::*; #(
    parameter int WINDOW_LENGTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item
);

    localparam logic [SUM_W-1:0] WIN_N = SUM_W'(WINDOW_LENGTH);

    // Configuration registers
    logic [DATA_W-1:0] center_reg, low_reg, high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= DATA_W'(1500);
            low_reg    <= DATA_W'(1000);
            high_reg   <= DATA_W'(2000);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CENTER: center_reg <= cfg_wdata;
                REG_LOW:    low_reg    <= cfg_wdata;
                REG_HIGH:   high_reg   <= cfg_wdata;
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Pipeline occupancy and per-stage readiness
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic m_valid_reg, m_valid_next;
    logic rdy1, rdy2, rdy3;

    assign rdy3    = !m_valid_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // Item decode
    logic accept, produce;
    logic enabled_reg, enabled_next;
    cell_ctrl_t cell_ctrl;
    logic [DATA_W-1:0] steer_new, motor_new;

    assign accept  = s_valid && s_ready;
    assign produce = accept && (s_item.mode == MODE_SAMPLE) && enabled_reg;

    assign cell_ctrl.shift = produce;
    assign cell_ctrl.fill  = accept && (s_item.mode == MODE_DISCONNECT);

    // Substitute centre for a missing value
    assign steer_new = (s_item.steer_raw == '0) ? center_reg : s_item.steer_raw;
    assign motor_new = (s_item.motor_raw == '0) ? center_reg : s_item.motor_raw;

    always_comb begin
        enabled_next = enabled_reg;
        if (accept) begin
            case (s_item.mode)
                MODE_CONNECT:    enabled_next = 1'b1;
                MODE_DISCONNECT: enabled_next = 1'b0;
                default:         enabled_next = enabled_reg;
            endcase
        end
    end

    // Chain of cells: index 0 is the incoming sample, the last tap the oldest entry
    logic [DATA_W-1:0] steer_chain [WINDOW_LENGTH+1];
    logic [DATA_W-1:0] motor_chain [WINDOW_LENGTH+1];

    assign steer_chain[0] = steer_new;
    assign motor_chain[0] = motor_new;

    for (genvar k = 0; k < WINDOW_LENGTH; k++) begin : g_cell
        rcbox_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (cell_ctrl),
            .center   (center_reg),
            .steer_in (steer_chain[k]),
            .motor_in (motor_chain[k]),
            .steer_q  (steer_chain[k+1]),
            .motor_q  (motor_chain[k+1])
        );
    end

    // Running window sums: add the newcomer, take off the entry that falls out
    logic [SUM_W-1:0] steer_sum_reg, steer_sum_next;
    logic [SUM_W-1:0] motor_sum_reg, motor_sum_next;
    logic [SUM_W-1:0] fill_sum;

    assign fill_sum = SUM_W'(SUM_W'(center_reg) * WIN_N);

    always_comb begin
        steer_sum_next = steer_sum_reg;
        motor_sum_next = motor_sum_reg;
        if (cell_ctrl.fill) begin
            steer_sum_next = fill_sum;
            motor_sum_next = fill_sum;
        end else if (cell_ctrl.shift) begin
            steer_sum_next = steer_sum_reg - SUM_W'(steer_chain[WINDOW_LENGTH])
                             + SUM_W'(steer_new);
            motor_sum_next = motor_sum_reg - SUM_W'(motor_chain[WINDOW_LENGTH])
                             + SUM_W'(motor_new);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= 1'b0;
            steer_sum_reg <= '0;
            motor_sum_reg <= '0;
        end else begin
            enabled_reg   <= enabled_next;
            steer_sum_reg <= steer_sum_next;
            motor_sum_reg <= motor_sum_next;
        end
    end

    // Stage 1: snapshot of the sums after this sample
    logic [SUM_W-1:0] steer_s1_reg, motor_s1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            steer_s1_reg <= steer_sum_next;
            motor_s1_reg <= motor_sum_next;
        end
    end

    // Stage 2: reciprocal multiply inside the dividers; output combines the correction
    logic [SUM_W-1:0] steer_mean, motor_mean;

    rcbox_div #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_steer_div (
        .aclk   (aclk),
        .load   (rdy2),
        .sum_in (steer_s1_reg),
        .mean   (steer_mean)
    );

    rcbox_div #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_motor_div (
        .aclk   (aclk),
        .load   (rdy2),
        .sum_in (motor_s1_reg),
        .mean   (motor_mean)
    );

    // Stage 3: snap into the output register
    out_item_t m_item_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            m_item_reg.steer_out <= snap_mean(steer_mean, center_reg, low_reg, high_reg);
            m_item_reg.motor_out <= snap_mean(motor_mean, center_reg, low_reg, high_reg);
        end
    end

    // Advance the valid bits wherever the next stage can take an item
    always_comb begin
        v1_next      = rdy1 ? produce     : v1_reg;
        v2_next      = rdy2 ? v1_reg      : v2_reg;
        m_valid_next = rdy3 ? v2_reg      : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // A disconnect always disarms sampling
    a_disconnect_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_item.mode == MODE_DISCONNECT)) |=> !enabled_reg)
        else $error("sampling still armed after disconnect");

    // A sample taken while disarmed launches nothing
    a_disarmed_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !enabled_reg) |=> !v1_reg)
        else $error("result launched while disarmed");

    // Input stalls only with the whole pipeline full
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && m_valid_reg))
        else $error("input stalled with a free stage");

    // A result appears only from an occupied stage 2
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(v2_reg))
        else $error("result appeared without a stage 2 item");

endmodule
